### hw/rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same, including reset cycles
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hw/rtl/mmid_pkg.sv
// ---------------------------------------------------------------------------
// mmid_pkg: shared types and constants for the mask-match decoder
// Opcode table, mode codes and the decode result record.
// ---------------------------------------------------------------------------
package mmid_pkg;

   localparam logic [4:0] MD_NONE = 5'd0, MD_RD = 5'd1, MD_RDRR = 5'd2, MD_RDRR4 = 5'd3,
      MD_RDRR3 = 5'd4, MD_RDRRW = 5'd5, MD_RPK = 5'd6, MD_RD4K = 5'd7, MD_RDK3 = 5'd8,
      MD_YZK = 5'd9, MD_RDX = 5'd10, MD_RDXINC = 5'd11, MD_RDXDEC = 5'd12, MD_YZ = 5'd13,
      MD_YZINC = 5'd14, MD_YZDEC = 5'd15, MD_Z = 5'd16, MD_ZINC = 5'd17, MD_IOK3 = 5'd18,
      MD_IO = 5'd19, MD_K4 = 5'd20, MD_BRANCH = 5'd21, MD_OFF12 = 5'd22,
      MD_ADDR16 = 5'd23, MD_ADDR22 = 5'd24;

   localparam logic [6:0] MN_RSVD = 7'd0, MN_NOP = 7'd1, MN_MOVW = 7'd2, MN_MULS = 7'd3,
      MN_MULSU = 7'd4, MN_FMUL = 7'd5, MN_FMULS = 7'd6, MN_FMULU = 7'd7, MN_CPC = 7'd8,
      MN_CP = 7'd9, MN_SBC = 7'd10, MN_SUB = 7'd11, MN_ADD = 7'd12, MN_ADC = 7'd13,
      MN_CPSE = 7'd14, MN_AND = 7'd15, MN_EOR = 7'd16, MN_OR = 7'd17, MN_MOV = 7'd18,
      MN_CPI = 7'd19, MN_SBCI = 7'd20, MN_SUBI = 7'd21, MN_ORI = 7'd22, MN_ANDI = 7'd23,
      MN_LD = 7'd24, MN_ST = 7'd25, MN_LPM = 7'd26, MN_ELPM = 7'd27, MN_XCH = 7'd28,
      MN_LAS = 7'd29, MN_LAC = 7'd30, MN_LAT = 7'd31, MN_POP = 7'd32, MN_PUSH = 7'd33,
      MN_COM = 7'd34, MN_NEG = 7'd35, MN_SWAP = 7'd36, MN_INC = 7'd37, MN_ASR = 7'd38,
      MN_LSR = 7'd39, MN_ROR = 7'd40, MN_RET = 7'd41, MN_RETI = 7'd42, MN_SLEEP = 7'd43,
      MN_BREAK = 7'd44, MN_WDR = 7'd45, MN_SPM = 7'd46, MN_DEC = 7'd47, MN_DES = 7'd48,
      MN_JMP = 7'd49, MN_CALL = 7'd50, MN_ADIW = 7'd51, MN_SBIW = 7'd52, MN_CBI = 7'd53,
      MN_SBI = 7'd54, MN_SBIC = 7'd55, MN_SBIS = 7'd56, MN_MUL = 7'd57, MN_IN = 7'd58,
      MN_OUT = 7'd59, MN_LDI = 7'd60, MN_BLD = 7'd61, MN_BST = 7'd62, MN_SBRC = 7'd63,
      MN_SBRS = 7'd64, MN_BRCC = 7'd65, MN_SEC = 7'd81, MN_CLC = 7'd89;

   typedef struct packed {
      logic [15:0] mask;
      logic [15:0] val;
      logic [6:0]  mn;
      logic [4:0]  md;
   } entry_type;

   typedef struct packed {
      logic [15:0] instr_word;
      logic [15:0] next_word;
      logic [15:0] instr_addr;
   } item_type;

   typedef struct packed {
      logic        matched;
      logic [6:0]  mnemonic_code;
      logic [4:0]  mode_code;
   } hit_type;

   typedef struct packed {
      logic        matched;
      logic [6:0]  mnemonic_code;
      logic [4:0]  mode_code;
      logic [1:0]  word_count;
      logic [4:0]  reg_d;
      logic [4:0]  reg_r;
      logic [7:0]  immediate;
      logic [5:0]  io_address;
      logic        ptr_is_y;
      logic        eind_flag;
      logic [22:0] target_addr;
   } result_type;

   function automatic entry_type ent(input logic [15:0] m, input logic [15:0] v,
                                     input logic [6:0] n, input logic [4:0] d);
      entry_type e;
      e.mask = m; e.val = v; e.mn = n; e.md = d;
      return e;
   endfunction

   function automatic entry_type table_entry(input int i);
      entry_type e;
      e = ent(16'h0000, 16'h0001, MN_RSVD, MD_NONE);
      case (i)
         0: e = ent(16'hffff, 16'h0000, MN_NOP, MD_NONE);
         1: e = ent(16'hff00, 16'h0100, MN_MOVW, MD_RDRRW);
         2: e = ent(16'hff00, 16'h0200, MN_MULS, MD_RDRR4);
         3: e = ent(16'hff88, 16'h0300, MN_MULSU, MD_RDRR3);
         4: e = ent(16'hff88, 16'h0308, MN_FMUL, MD_RDRR3);
         5: e = ent(16'hff88, 16'h0380, MN_FMULS, MD_RDRR3);
         6: e = ent(16'hff88, 16'h0388, MN_FMULU, MD_RDRR3);
         7: e = ent(16'hfc00, 16'h0400, MN_CPC, MD_RDRR);
         8: e = ent(16'hfc00, 16'h1400, MN_CP, MD_RDRR);
         9: e = ent(16'hfc00, 16'h0800, MN_SBC, MD_RDRR);
         10: e = ent(16'hfc00, 16'h1800, MN_SUB, MD_RDRR);
         11: e = ent(16'hf800, 16'h0800, MN_ADD, MD_RDRR);
         12: e = ent(16'hf800, 16'h1800, MN_ADC, MD_RDRR);
         13: e = ent(16'hfc00, 16'h1000, MN_CPSE, MD_RDRR);
         14: e = ent(16'hfc00, 16'h2000, MN_AND, MD_RDRR);
         15: e = ent(16'hfc00, 16'h2400, MN_EOR, MD_RDRR);
         16: e = ent(16'hfc00, 16'h2800, MN_OR, MD_RDRR);
         17: e = ent(16'hfc00, 16'h2c00, MN_MOV, MD_RDRR);
         18: e = ent(16'hf000, 16'h3000, MN_CPI, MD_RD4K);
         19: e = ent(16'hf000, 16'h4000, MN_SBCI, MD_RD4K);
         20: e = ent(16'hf000, 16'h5000, MN_SUBI, MD_RD4K);
         21: e = ent(16'hf000, 16'h6000, MN_ORI, MD_RD4K);
         22: e = ent(16'hf000, 16'h7000, MN_ANDI, MD_RD4K);
         23: e = ent(16'hd200, 16'h8000, MN_LD, MD_YZK);
         24: e = ent(16'hd200, 16'h8200, MN_ST, MD_YZK);
         25: e = ent(16'hfe0f, 16'h9000, MN_LD, MD_ADDR16);
         26: e = ent(16'hfe0f, 16'h9200, MN_ST, MD_ADDR16);
         27: e = ent(16'hfe07, 16'h9001, MN_LD, MD_YZINC);
         28: e = ent(16'hfe07, 16'h9201, MN_ST, MD_YZINC);
         29: e = ent(16'hfe07, 16'h9002, MN_LD, MD_YZDEC);
         30: e = ent(16'hfe07, 16'h9202, MN_ST, MD_YZDEC);
         31: e = ent(16'hfe0f, 16'h9004, MN_LPM, MD_YZ);
         32: e = ent(16'hfe0f, 16'h9005, MN_LPM, MD_YZINC);
         33: e = ent(16'hfe0f, 16'h9006, MN_ELPM, MD_YZ);
         34: e = ent(16'hfe0f, 16'h9007, MN_ELPM, MD_YZINC);
         35: e = ent(16'hfe0f, 16'h9204, MN_XCH, MD_YZ);
         36: e = ent(16'hfe0f, 16'h9205, MN_LAS, MD_YZ);
         37: e = ent(16'hfe0f, 16'h9206, MN_LAC, MD_YZ);
         38: e = ent(16'hfe0f, 16'h9207, MN_LAT, MD_YZ);
         39: e = ent(16'hfe0f, 16'h900c, MN_LD, MD_RDX);
         40: e = ent(16'hfe0f, 16'h920c, MN_ST, MD_RDX);
         41: e = ent(16'hfe0f, 16'h900d, MN_LD, MD_RDXINC);
         42: e = ent(16'hfe0f, 16'h920d, MN_ST, MD_RDXINC);
         43: e = ent(16'hfe0f, 16'h900e, MN_LD, MD_RDXDEC);
         44: e = ent(16'hfe0f, 16'h920e, MN_ST, MD_RDXDEC);
         45: e = ent(16'hfe0f, 16'h900f, MN_POP, MD_RD);
         46: e = ent(16'hfe0f, 16'h920f, MN_PUSH, MD_RD);
         47: e = ent(16'hfe0f, 16'h9400, MN_COM, MD_RD);
         48: e = ent(16'hfe0f, 16'h9401, MN_NEG, MD_RD);
         49: e = ent(16'hfe0f, 16'h9402, MN_SWAP, MD_RD);
         50: e = ent(16'hfe0f, 16'h9403, MN_INC, MD_RD);
         51: e = ent(16'hfe0f, 16'h9404, MN_RSVD, MD_NONE);
         52: e = ent(16'hfe0f, 16'h9405, MN_ASR, MD_RD);
         53: e = ent(16'hfe0f, 16'h9406, MN_LSR, MD_RD);
         54: e = ent(16'hfe0f, 16'h9407, MN_ROR, MD_RD);
         55: e = ent(16'hffff, 16'h9408, MN_SEC + 7'd0, MD_NONE);
         56: e = ent(16'hffff, 16'h9418, MN_SEC + 7'd1, MD_NONE);
         57: e = ent(16'hffff, 16'h9428, MN_SEC + 7'd2, MD_NONE);
         58: e = ent(16'hffff, 16'h9438, MN_SEC + 7'd3, MD_NONE);
         59: e = ent(16'hffff, 16'h9448, MN_SEC + 7'd4, MD_NONE);
         60: e = ent(16'hffff, 16'h9458, MN_SEC + 7'd5, MD_NONE);
         61: e = ent(16'hffff, 16'h9468, MN_SEC + 7'd6, MD_NONE);
         62: e = ent(16'hffff, 16'h9478, MN_SEC + 7'd7, MD_NONE);
         63: e = ent(16'hffff, 16'h9488, MN_CLC + 7'd0, MD_NONE);
         64: e = ent(16'hffff, 16'h9498, MN_CLC + 7'd1, MD_NONE);
         65: e = ent(16'hffff, 16'h94a8, MN_CLC + 7'd2, MD_NONE);
         66: e = ent(16'hffff, 16'h94b8, MN_CLC + 7'd3, MD_NONE);
         67: e = ent(16'hffff, 16'h94c8, MN_CLC + 7'd4, MD_NONE);
         68: e = ent(16'hffff, 16'h94d8, MN_CLC + 7'd5, MD_NONE);
         69: e = ent(16'hffff, 16'h94e8, MN_CLC + 7'd6, MD_NONE);
         70: e = ent(16'hffff, 16'h94f8, MN_CLC + 7'd7, MD_NONE);
         71: e = ent(16'hffff, 16'h9508, MN_RET, MD_NONE);
         72: e = ent(16'hffff, 16'h9518, MN_RETI, MD_NONE);
         73: e = ent(16'hffef, 16'h9528, MN_RSVD, MD_NONE);
         74: e = ent(16'hffcf, 16'h9548, MN_RSVD, MD_NONE);
         75: e = ent(16'hffff, 16'h9588, MN_SLEEP, MD_NONE);
         76: e = ent(16'hffff, 16'h9598, MN_BREAK, MD_NONE);
         77: e = ent(16'hffff, 16'h95a8, MN_WDR, MD_NONE);
         78: e = ent(16'hffff, 16'h95b8, MN_RSVD, MD_NONE);
         79: e = ent(16'hffff, 16'h95c8, MN_LPM, MD_NONE);
         80: e = ent(16'hffff, 16'h95d8, MN_ELPM, MD_NONE);
         81: e = ent(16'hffff, 16'h95e8, MN_SPM, MD_NONE);
         82: e = ent(16'hffff, 16'h95f8, MN_SPM, MD_ZINC);
         83: e = ent(16'hffef, 16'h9409, MN_JMP, MD_Z);
         84: e = ent(16'hffef, 16'h9509, MN_CALL, MD_Z);
         85: e = ent(16'hfe0f, 16'h940a, MN_DEC, MD_RD);
         86: e = ent(16'hff0f, 16'h940b, MN_DES, MD_K4);
         87: e = ent(16'hfe0e, 16'h940c, MN_JMP, MD_ADDR22);
         88: e = ent(16'hfe0e, 16'h940e, MN_CALL, MD_ADDR22);
         89: e = ent(16'hff00, 16'h9600, MN_ADIW, MD_RPK);
         90: e = ent(16'hff00, 16'h9700, MN_SBIW, MD_RPK);
         91: e = ent(16'hff00, 16'h9800, MN_CBI, MD_IOK3);
         92: e = ent(16'hff00, 16'h9a00, MN_SBI, MD_IOK3);
         93: e = ent(16'hff00, 16'h9900, MN_SBIC, MD_IOK3);
         94: e = ent(16'hff00, 16'h9b00, MN_SBIS, MD_IOK3);
         95: e = ent(16'hfc00, 16'h9c00, MN_MUL, MD_RDRR);
         96: e = ent(16'hf800, 16'hb000, MN_IN, MD_IO);
         97: e = ent(16'hf800, 16'hb800, MN_OUT, MD_IO);
         98: e = ent(16'hf000, 16'hc000, MN_JMP, MD_OFF12);
         99: e = ent(16'hf000, 16'hd000, MN_CALL, MD_OFF12);
         100: e = ent(16'hf000, 16'he000, MN_LDI, MD_RD4K);
         101: e = ent(16'hfc07, 16'hf400, MN_BRCC + 7'd0, MD_BRANCH);
         102: e = ent(16'hfc07, 16'hf000, MN_BRCC + 7'd1, MD_BRANCH);
         103: e = ent(16'hfc07, 16'hf401, MN_BRCC + 7'd2, MD_BRANCH);
         104: e = ent(16'hfc07, 16'hf001, MN_BRCC + 7'd3, MD_BRANCH);
         105: e = ent(16'hfc07, 16'hf402, MN_BRCC + 7'd4, MD_BRANCH);
         106: e = ent(16'hfc07, 16'hf002, MN_BRCC + 7'd5, MD_BRANCH);
         107: e = ent(16'hfc07, 16'hf403, MN_BRCC + 7'd6, MD_BRANCH);
         108: e = ent(16'hfc07, 16'hf003, MN_BRCC + 7'd7, MD_BRANCH);
         109: e = ent(16'hfc07, 16'hf404, MN_BRCC + 7'd8, MD_BRANCH);
         110: e = ent(16'hfc07, 16'hf004, MN_BRCC + 7'd9, MD_BRANCH);
         111: e = ent(16'hfc07, 16'hf405, MN_BRCC + 7'd10, MD_BRANCH);
         112: e = ent(16'hfc07, 16'hf005, MN_BRCC + 7'd11, MD_BRANCH);
         113: e = ent(16'hfc07, 16'hf406, MN_BRCC + 7'd12, MD_BRANCH);
         114: e = ent(16'hfc07, 16'hf006, MN_BRCC + 7'd13, MD_BRANCH);
         115: e = ent(16'hfc07, 16'hf407, MN_BRCC + 7'd14, MD_BRANCH);
         116: e = ent(16'hfc07, 16'hf007, MN_BRCC + 7'd15, MD_BRANCH);
         117: e = ent(16'hfe08, 16'hf800, MN_BLD, MD_RDK3);
         118: e = ent(16'hfe08, 16'hfa00, MN_BST, MD_RDK3);
         119: e = ent(16'hfe08, 16'hfc00, MN_SBRC, MD_RDK3);
         120: e = ent(16'hfe08, 16'hfe00, MN_SBRS, MD_RDK3);
         121: e = ent(16'hf808, 16'hf808, MN_RSVD, MD_NONE);
         122: e = ent(16'hf800, 16'ha800, MN_ST, MD_RD4K);
         123: e = ent(16'hf800, 16'ha000, MN_LD, MD_RD4K);
         default: e = ent(16'h0000, 16'h0001, MN_RSVD, MD_NONE);
      endcase
      return e;
   endfunction

   localparam int NumEntries = 124;

endpackage

### hw/rtl/mmid_match.sv
// ---------------------------------------------------------------------------
// mmid_match: two-stage first-match search over the opcode table
// Stage 1 compares all entries and registers the hit vector;
// stage 2 picks the first entry that hit, in table order.
// ---------------------------------------------------------------------------
module mmid_match (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  mmid_pkg::item_type  in_item,
   output logic                out_valid,
   output mmid_pkg::item_type  out_item,
   output mmid_pkg::hit_type   out_hit
);
   import mmid_pkg::*;

   logic [NumEntries-1:0] hits_in, hits_ff;
   logic                  v1_ff, v2_ff;
   item_type              item1_ff, item2_ff;
   hit_type               hit_in, hit_ff;

   always_comb begin
      entry_type e;
      for (int i = 0; i < NumEntries; i++) begin
         e = table_entry(i);
         hits_in[i] = ((in_item.instr_word & e.mask) == e.val);
      end
   end

   // priority select: first entry with a hit
   always_comb begin
      logic found;
      entry_type e;
      found  = 1'b0;
      hit_in = '0;
      for (int i = 0; i < NumEntries; i++) begin
         e = table_entry(i);
         if (!found && hits_ff[i]) begin
            found = 1'b1;
            hit_in.matched       = 1'b1;
            hit_in.mnemonic_code = e.mn;
            hit_in.mode_code     = e.md;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hits_ff  <= hits_in;
         item1_ff <= in_item;
         hit_ff   <= hit_in;
         item2_ff <= item1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item2_ff;
   assign out_hit   = hit_ff;
endmodule

### hw/rtl/mmid_fields.sv
// ---------------------------------------------------------------------------
// mmid_fields: operand field extraction and target address, one stage
// ---------------------------------------------------------------------------
module mmid_fields (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  mmid_pkg::item_type   in_item,
   input  mmid_pkg::hit_type    in_hit,
   output logic                 out_valid,
   output mmid_pkg::result_type out_res
);
   import mmid_pkg::*;

   result_type res_in, res_ff;
   logic       valid_ff;
   logic [15:0] w, pc, off7, off12;

   always_comb begin
      w     = in_item.instr_word;
      pc    = in_item.instr_addr;
      off7  = {{8{w[9]}}, w[9:3], 1'b0};
      off12 = {{3{w[11]}}, w[11:0], 1'b0};
      res_in = '0;
      res_in.word_count    = 2'd1;
      res_in.matched       = in_hit.matched;
      res_in.mnemonic_code = in_hit.mnemonic_code;
      res_in.mode_code     = in_hit.mode_code;
      if (in_hit.matched) begin
         case (in_hit.mode_code)
            MD_RD, MD_RDX, MD_RDXINC, MD_RDXDEC: res_in.reg_d = w[8:4];
            MD_YZ, MD_YZINC, MD_YZDEC: begin
               res_in.reg_d = w[8:4];
               res_in.ptr_is_y = w[3];
            end
            MD_RDRR: begin
               res_in.reg_d = w[8:4];
               res_in.reg_r = {w[9], w[3:0]};
            end
            MD_RDRR4, MD_RDRRW: begin
               res_in.reg_d = {1'b0, w[7:4]};
               res_in.reg_r = {1'b0, w[3:0]};
            end
            MD_RDRR3: begin
               res_in.reg_d = {2'b0, w[6:4]};
               res_in.reg_r = {2'b0, w[2:0]};
            end
            MD_RPK: begin
               res_in.reg_d = {3'b0, w[5:4]};
               res_in.immediate = {2'b0, w[7:6], w[3:0]};
            end
            MD_RD4K: begin
               res_in.reg_d = {1'b0, w[7:4]};
               res_in.immediate = {w[11:8], w[3:0]};
            end
            MD_RDK3: begin
               res_in.reg_d = w[8:4];
               res_in.immediate = {5'b0, w[2:0]};
            end
            MD_YZK: begin
               res_in.reg_d = w[8:4];
               res_in.immediate = {2'b0, w[13], w[11:10], w[2:0]};
               res_in.ptr_is_y = w[3];
            end
            MD_Z: res_in.eind_flag = w[4];
            MD_IOK3: begin
               res_in.immediate = {5'b0, w[2:0]};
               res_in.io_address = {1'b0, w[7:3]};
            end
            MD_IO: begin
               res_in.reg_d = w[8:4];
               res_in.io_address = {w[10:9], w[3:0]};
            end
            MD_K4: res_in.immediate = {4'b0, w[7:4]};
            MD_BRANCH: res_in.target_addr = {7'b0, pc + off7 + 16'd2};
            MD_OFF12: res_in.target_addr = {7'b0, pc + off12 + 16'd2};
            MD_ADDR16: begin
               res_in.word_count = 2'd2;
               res_in.target_addr = {7'b0, in_item.next_word};
            end
            MD_ADDR22: begin
               res_in.word_count = 2'd2;
               res_in.target_addr = {w[8:4], w[0], in_item.next_word, 1'b0};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
endmodule

### hw/rtl/mask_match_instruction_decoder_top.sv
// An accepted req word is registered in the match, select and fields stages on its way to rsp_tvalid.
// Throughput: one word per cycle while the rsp side is not stalled; the three-stage match/select/extract pipe sets it.
// A stalled rsp side freezes the whole pipe; no word is lost or repeated.
// Reset: synchronous, active high, clears the stage valid bits only.
// ---------------------------------------------------------------------------
// mask_match_instruction_decoder_top: pipelined mask/value opcode decoder
// Decodes one instruction word against the opcode table per cycle while the rsp side is not stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module mask_match_instruction_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // instr_word[15:0], next_word[31:16], instr_addr[47:32]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // matched[0], mnemonic_code[7:1], mode_code[12:8], word_count[14:13],
   // reg_d[19:15], reg_r[24:20], immediate[32:25], io_address[38:33],
   // ptr_is_y[39], eind_flag[40], target_addr[63:41]
   output logic [63:0] rsp_tdata
);
   import mmid_pkg::*;

   logic       advance;
   item_type   item_in, item_m;
   hit_type    hit_m;
   logic       valid_m;
   result_type res;

   // pipe moves when the output slot is empty or being drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   assign item_in.instr_word = req_tdata[15:0];
   assign item_in.next_word  = req_tdata[31:16];
   assign item_in.instr_addr = req_tdata[47:32];

   mmid_match u_match (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_tvalid), .in_item(item_in),
      .out_valid(valid_m), .out_item(item_m), .out_hit(hit_m)
   );

   mmid_fields u_fields (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(valid_m), .in_item(item_m), .in_hit(hit_m),
      .out_valid(rsp_tvalid), .out_res(res)
   );

   assign rsp_tdata = {res.target_addr, res.eind_flag, res.ptr_is_y, res.io_address,
                       res.immediate, res.reg_r, res.reg_d, res.word_count,
                       res.mode_code, res.mnemonic_code, res.matched};

   `ASSERT_IMP(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp held")
   `ASSERT_IMP(a_nomatch, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[63:1] == 63'd4096, "unmatched nonzero")
   `ASSERT_IMP(a_len, clock, reset, rsp_tvalid |-> (rsp_tdata[14:13] == 2'd2) == (rsp_tdata[12:8] == MD_ADDR16 || rsp_tdata[12:8] == MD_ADDR22), "word count")
endmodule
